[rtl/gff_pkg.sv]
// Package for the grid flood fill: default grid size and opcodes.
`default_nettype none
package gff_pkg;
	localparam int GFF_ROWS = 16;
	localparam int GFF_COLS = 10;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_FILL  = 2'd2;
endpackage
`default_nettype wire

[rtl/gff_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module gff_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 160,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

[rtl/grid_flood_fill.sv]
// Grid flood fill, 4-connected, with write/read/fill commands on one channel.
//
//   channel | handshake          | word
//   --------+--------------------+-----------------------------
//   in      | in_valid/in_ready  | opcode, row, col, color
//   out     | out_valid/out_ready| read_color, changed_count
//
// Write, out of range or unused opcode: take the word, post the result; a read also waits on the RAM.
// Fill: take the word, sweep the visited RAM clear (ROWS*COLS cells), read and write the seed,
// then for each cell of the region pop it off the stack and probe its four neighbors one at a time
// through the grid RAM read port, then find the stack empty and post the result.
// Reset clears the sequencer and output valid; RAM contents are not reset.
// in_ready is high only while idle; a result waits in the output register
// and the next word is taken while it waits.
`default_nettype none
module grid_flood_fill
	import gff_pkg::*;
#(
	parameter int ROWS = GFF_ROWS,
	parameter int COLS = GFF_COLS
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] opcode,
	input  wire logic [3:0] row,
	input  wire logic [3:0] col,
	input  wire logic [3:0] color,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [3:0]      read_color,
	output logic [7:0]      changed_count
);
	localparam int CELLS = ROWS * COLS;
	localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;
	localparam int IW    = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int DW    = $clog2(CELLS + 1);
	localparam int SW    = RW + CW;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_WAIT,
		ST_CLEAR,
		ST_SEED_RD,
		ST_SEED_WR,
		ST_POP,
		ST_POP_WAIT,
		ST_NB,
		ST_CHK,
		ST_DONE
	} state_t;

	state_t          state_q;
	logic [RW-1:0]   r_q, nr_q, seed_r_q;
	logic [CW-1:0]   c_q, nc_q, seed_c_q;
	logic [3:0]      newc_q, oldc_q;
	logic [7:0]      cnt_q;
	logic [DW-1:0]   depth_q;
	logic [IW-1:0]   clr_q;
	logic [1:0]      d_q;
	logic [3:0]      res_rd_q;
	logic [7:0]      res_cnt_q;
	logic            out_valid_q;
	logic [3:0]      read_color_q;
	logic [7:0]      changed_count_q;

	// RAM ports
	logic            col_we, vis_we, stk_we;
	logic [IW-1:0]   col_waddr, col_raddr, vis_waddr, stk_waddr, stk_raddr;
	logic [3:0]      col_wdata, col_rdata;
	logic            vis_wdata;
	logic [0:0]      vis_rdata;
	logic [SW-1:0]   stk_wdata, stk_rdata;

	logic            accept, in_ok, nb_ok, hit;
	logic [IW-1:0]   in_idx, seed_idx, nb_idx, nbq_idx;
	logic [RW-1:0]   nr;
	logic [CW-1:0]   nc;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign in_ok    = (32'(row) < ROWS) && (32'(col) < COLS);
	assign in_idx   = IW'(32'(row) * COLS + 32'(col));
	assign seed_idx = IW'(32'(seed_r_q) * COLS + 32'(seed_c_q));
	assign nbq_idx  = IW'(32'(nr_q) * COLS + 32'(nc_q));
	assign nb_idx   = IW'(32'(nr) * COLS + 32'(nc));
	assign hit      = !vis_rdata[0] && (col_rdata == oldc_q);

	// neighbor order: down, up, right, left
	always_comb begin
		nr    = r_q;
		nc    = c_q;
		nb_ok = 1'b0;
		case (d_q)
			2'd0: begin
				nr    = r_q + 1'b1;
				nb_ok = (32'(r_q) != ROWS - 1);
			end
			2'd1: begin
				nr    = r_q - 1'b1;
				nb_ok = (r_q != '0);
			end
			2'd2: begin
				nc    = c_q + 1'b1;
				nb_ok = (32'(c_q) != COLS - 1);
			end
			default: begin
				nc    = c_q - 1'b1;
				nb_ok = (c_q != '0);
			end
		endcase
	end

	always_comb begin
		col_we    = 1'b0;
		col_waddr = in_idx;
		col_wdata = color;
		col_raddr = in_idx;
		vis_we    = 1'b0;
		vis_waddr = clr_q;
		vis_wdata = 1'b0;
		stk_we    = 1'b0;
		stk_waddr = IW'(depth_q);
		stk_wdata = {nr_q, nc_q};
		stk_raddr = IW'(depth_q - 1'b1);
		case (state_q)
			ST_IDLE: begin
				col_we = accept && in_ok && (opcode == OP_WRITE);
			end
			ST_CLEAR: begin
				vis_we = 1'b1;
			end
			ST_SEED_RD: begin
				col_raddr = seed_idx;
			end
			ST_SEED_WR: begin
				col_we    = 1'b1;
				col_waddr = seed_idx;
				col_wdata = newc_q;
				vis_we    = 1'b1;
				vis_waddr = seed_idx;
				vis_wdata = 1'b1;
				stk_we    = 1'b1;
				stk_waddr = '0;
				stk_wdata = {seed_r_q, seed_c_q};
			end
			ST_NB: begin
				col_raddr = nb_idx;
			end
			ST_CHK: begin
				col_we    = hit;
				col_waddr = nbq_idx;
				col_wdata = newc_q;
				vis_we    = hit;
				vis_waddr = nbq_idx;
				vis_wdata = 1'b1;
				stk_we    = hit && (depth_q < DW'(CELLS));
			end
			default: begin
			end
		endcase
	end

	gff_ram #(.WIDTH(4), .DEPTH(CELLS)) u_colors (
		.clk   (clk),
		.we    (col_we),
		.waddr (col_waddr),
		.wdata (col_wdata),
		.raddr (col_raddr),
		.rdata (col_rdata)
	);

	// visited map shares the grid read address
	gff_ram #(.WIDTH(1), .DEPTH(CELLS)) u_visited (
		.clk   (clk),
		.we    (vis_we),
		.waddr (vis_waddr),
		.wdata (vis_wdata),
		.raddr (col_raddr),
		.rdata (vis_rdata)
	);

	gff_ram #(.WIDTH(SW), .DEPTH(CELLS)) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			depth_q     <= '0;
			clr_q       <= '0;
			d_q         <= '0;
		end else begin
			if ((state_q == ST_DONE) && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						res_rd_q  <= '0;
						res_cnt_q <= '0;
						seed_r_q  <= RW'(row);
						seed_c_q  <= CW'(col);
						newc_q    <= color;
						clr_q     <= '0;
						state_q   <= ST_DONE;
						if (in_ok && (opcode == OP_READ)) begin
							state_q <= ST_RD_WAIT;
						end else if (in_ok && (opcode == OP_FILL)) begin
							state_q <= ST_CLEAR;
						end
					end
				end
				ST_RD_WAIT: begin
					res_rd_q <= col_rdata;
					state_q  <= ST_DONE;
				end
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == CELLS - 1) begin
						state_q <= ST_SEED_RD;
					end
				end
				ST_SEED_RD: begin
					state_q <= ST_SEED_WR;
				end
				ST_SEED_WR: begin
					oldc_q  <= col_rdata;
					cnt_q   <= 8'd1;
					depth_q <= DW'(1);
					state_q <= ST_POP;
				end
				ST_POP: begin
					if (depth_q == '0) begin
						res_cnt_q <= cnt_q;
						state_q   <= ST_DONE;
					end else begin
						depth_q <= depth_q - 1'b1;
						state_q <= ST_POP_WAIT;
					end
				end
				ST_POP_WAIT: begin
					r_q     <= stk_rdata[SW-1:CW];
					c_q     <= stk_rdata[CW-1:0];
					d_q     <= '0;
					state_q <= ST_NB;
				end
				ST_NB: begin
					nr_q <= nr;
					nc_q <= nc;
					if (nb_ok) begin
						state_q <= ST_CHK;
					end else begin
						d_q <= d_q + 1'b1;
						if (d_q == 2'd3) begin
							state_q <= ST_POP;
						end
					end
				end
				ST_CHK: begin
					if (hit) begin
						if (cnt_q != 8'hFF) begin
							cnt_q <= cnt_q + 8'd1;
						end
						if (depth_q < DW'(CELLS)) begin
							depth_q <= depth_q + 1'b1;
						end
					end
					d_q     <= d_q + 1'b1;
					state_q <= (d_q == 2'd3) ? ST_POP : ST_NB;
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						read_color_q    <= res_rd_q;
						changed_count_q <= res_cnt_q;
						state_q         <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign read_color    = read_color_q;
	assign changed_count = changed_count_q;
endmodule
`default_nettype wire

[tb/sv/tb_grid_flood_fill.sv]
`timescale 1ns / 1ps
// Self-checking bench for grid_flood_fill: directed and random write, read, fill, out of range and unused-opcode words.
module tb_grid_flood_fill;
	import gff_pkg::*;

	localparam int CELLS = GFF_ROWS * GFF_COLS;
	localparam logic [1:0] OP_NONE = 2'd3;

	typedef struct packed {
		logic [3:0] read_color;
		logic [7:0] changed_count;
	} grid_reply_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [1:0] opcode;
	logic [3:0] row;
	logic [3:0] col;
	logic [3:0] color;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [3:0] read_color;
	logic [7:0] changed_count;

	logic [3:0]  grid_model [CELLS];
	grid_reply_t pending_replies [$];
	grid_reply_t want_reply;
	int          error_count = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;

	grid_flood_fill DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.opcode        (opcode),
		.row           (row),
		.col           (col),
		.color         (color),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.read_color    (read_color),
		.changed_count (changed_count)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#40_000_000;
		$display("tb_grid_flood_fill: errors");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		error_count++;
		$display("%0t ns: %s", $time, msg);
	endtask

	// recolor the 4-connected region of the seed, return the number of cells recolored
	function automatic logic [7:0] flood_region(input int seed, input logic [3:0] new_color);
		bit         seen [CELLS];
		int         walk [$];
		logic [3:0] old_color;
		int         region;
		int         cur;
		int         nr;
		int         nc;
		int         ni;
		old_color = grid_model[seed];
		region = 1;
		seen[seed] = 1'b1;
		grid_model[seed] = new_color;
		walk.push_back(seed);
		while (walk.size() > 0) begin
			cur = walk.pop_back();
			for (int d = 0; d < 4; d++) begin
				nr = cur / GFF_COLS;
				nc = cur % GFF_COLS;
				case (d)
					0: nr = nr + 1;
					1: nr = nr - 1;
					2: nc = nc + 1;
					default: nc = nc - 1;
				endcase
				if (nr < 0 || nr >= GFF_ROWS || nc < 0 || nc >= GFF_COLS)
					continue;
				ni = nr * GFF_COLS + nc;
				if (seen[ni] || grid_model[ni] != old_color)
					continue;
				seen[ni] = 1'b1;
				grid_model[ni] = new_color;
				region++;
				walk.push_back(ni);
			end
		end
		return (region > 255) ? 8'd255 : 8'(region);
	endfunction

	function automatic grid_reply_t predict_reply(input logic [1:0] op, input logic [3:0] r,
			input logic [3:0] c, input logic [3:0] colr);
		grid_reply_t rep;
		int          idx;
		rep = '0;
		if (int'(r) < GFF_ROWS && int'(c) < GFF_COLS) begin
			idx = int'(r) * GFF_COLS + int'(c);
			case (op)
				OP_WRITE: grid_model[idx] = colr;
				OP_READ:  rep.read_color = grid_model[idx];
				OP_FILL:  rep.changed_count = flood_region(idx, colr);
				default: ;
			endcase
		end
		return rep;
	endfunction

	// mostly a small palette so that regions grow
	function automatic logic [3:0] pick_color();
		if ($urandom_range(3) != 0)
			return 4'($urandom_range(2));
		return 4'($urandom_range(15));
	endfunction

	task automatic send_word(input logic [1:0] op, input logic [3:0] r, input logic [3:0] c,
			input logic [3:0] colr);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode   <= op;
		row      <= r;
		col      <= c;
		color    <= colr;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_replies.push_back(predict_reply(op, r, c, colr));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_replies.size() != 0);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_replies.size() == 0) begin
				report_mismatch("result word with nothing expected");
			end else begin
				want_reply = pending_replies.pop_front();
				if (read_color !== want_reply.read_color)
					report_mismatch($sformatf("read_color %0h, expected %0h",
						read_color, want_reply.read_color));
				if (changed_count !== want_reply.changed_count)
					report_mismatch($sformatf("changed_count %0d, expected %0d",
						changed_count, want_reply.changed_count));
			end
		end
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic load_grid();
		for (int r = 0; r < GFF_ROWS; r++)
			for (int c = 0; c < GFF_COLS; c++)
				send_word(OP_WRITE, 4'(r), 4'(c), 4'd0);
	endtask

	task automatic test_fill_whole_grid();
		send_word(OP_FILL, 4'd0, 4'd0, 4'd5);
		// same color again: region still walked and counted
		send_word(OP_FILL, 4'(GFF_ROWS - 1), 4'(GFF_COLS - 1), 4'd5);
		send_word(OP_READ, 4'd7, 4'd4, 4'd0);
	endtask

	task automatic test_write_read_extremes();
		send_word(OP_WRITE, 4'(GFF_ROWS - 1), 4'(GFF_COLS - 1), 4'd15);
		send_word(OP_WRITE, 4'd0, 4'd0, 4'd0);
		send_word(OP_WRITE, 4'd0, 4'(GFF_COLS - 1), 4'd10);
		send_word(OP_READ, 4'(GFF_ROWS - 1), 4'(GFF_COLS - 1), 4'd0);
		send_word(OP_READ, 4'd0, 4'd0, 4'd15);
		send_word(OP_READ, 4'd0, 4'(GFF_COLS - 1), 4'd0);
	endtask

	task automatic test_fill_single_cell();
		send_word(OP_FILL, 4'(GFF_ROWS - 1), 4'(GFF_COLS - 1), 4'd15);
		send_word(OP_FILL, 4'd0, 4'd0, 4'd3);
		send_word(OP_READ, 4'd0, 4'd0, 4'd0);
	endtask

	task automatic test_out_of_range();
		send_word(OP_WRITE, 4'd15, 4'd15, 4'd15);
		send_word(OP_WRITE, 4'd3, 4'(GFF_COLS), 4'd7);
		send_word(OP_READ, 4'd0, 4'(GFF_COLS), 4'd0);
		send_word(OP_FILL, 4'd8, 4'd12, 4'd1);
		send_word(OP_READ, 4'd3, 4'(GFF_COLS - 1), 4'd0);
	endtask

	task automatic test_unused_opcode();
		send_word(OP_NONE, 4'(GFF_ROWS - 1), 4'(GFF_COLS - 1), 4'd15);
		send_word(OP_NONE, 4'd0, 4'd0, 4'd0);
		send_word(OP_READ, 4'(GFF_ROWS - 1), 4'(GFF_COLS - 1), 4'd0);
	endtask

	task automatic test_random_mix(input int words);
		int         counted;
		int         pick;
		logic [3:0] r;
		logic [3:0] c;
		counted = 0;
		while (counted < words) begin
			pick = $urandom_range(99);
			r = 4'($urandom_range(GFF_ROWS - 1));
			c = 4'($urandom_range(GFF_COLS - 1));
			if (pick < 40) begin
				send_word(OP_WRITE, r, c, pick_color());
				counted++;
			end else if (pick < 64) begin
				send_word(OP_READ, r, c, 4'($urandom_range(15)));
				counted++;
			end else if (pick < 88) begin
				send_word(OP_FILL, r, c, pick_color());
				counted++;
			end else if (pick < 94) begin
				send_word(2'($urandom_range(2)), r, 4'($urandom_range(15, GFF_COLS)),
					4'($urandom_range(15)));
			end else begin
				send_word(OP_NONE, 4'($urandom_range(15)), 4'($urandom_range(15)),
					4'($urandom_range(15)));
			end
		end
	endtask

	initial begin
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		opcode    <= OP_WRITE;
		row       <= 4'd0;
		col       <= 4'd0;
		color     <= 4'd0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		load_grid();
		test_fill_whole_grid();
		test_write_read_extremes();
		test_fill_single_cell();
		test_out_of_range();
		test_unused_opcode();
		wait_drained();

		send_idle_pct = 15;
		recv_idle_pct = 54;
		test_random_mix(200);
		wait_drained();

		send_idle_pct = 54;
		recv_idle_pct = 15;
		test_random_mix(200);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_mix(200);
		wait_drained();

		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("tb_grid_flood_fill: clean");
		else
			$display("tb_grid_flood_fill: errors");
		$finish;
	end
endmodule
